FILE: hw/rtl/sma_pkg.sv
package sma_pkg;

	// field widths
	localparam int unsigned VOXEL_W = 8;
	localparam int unsigned CHAN_W  = 4;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 16;

	// stream data widths, padded to whole bytes
	localparam int unsigned IN_FIELDS_W = VOXEL_W + CHAN_W + VALUE_W + COUNT_W;
	localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W  = ((VALUE_W + 7) / 8) * 8;

	// default table shape
	localparam int unsigned VOXELS_DEF   = 256;
	localparam int unsigned CHANNELS_DEF = 16;

	// quotient bits retired per divider cycle
	localparam int unsigned DIV_BITS  = 4;
	localparam int unsigned DIV_ITERS = VALUE_W / DIV_BITS;

	typedef enum logic {
		FUNC_ACCUMULATE = 1'b0,
		FUNC_READ       = 1'b1
	} func_t;

endpackage

FILE: hw/rtl/scatter_mean_accumulate.sv
// channel  | dir | tdata (low bit up)                                   | tuser
// ---------+-----+------------------------------------------------------+-----------
// s_axis   | in  | voxel_index 8, channel_index 4, feature_value 32,   | func 1
//          |     | voxel_count 16, 4 zero bits                          |
// m_axis   | out | entry_value 32                                       | skipped 1
//
// one item at a time; an in-range accumulate with a nonzero count passes the radix-16 divider,
// then a table read and a write back into the output register on the single memory port;
// other items skip the divider and go straight to the table read and the write back
// s_axis_tready rises with the result, so the next transfer waits for the write back
// after reset a sweep zeroes all VOXELS * CHANNELS table entries with s_axis_tready low
// a stalled output holds the next finished item in write-back, and with it s_axis
module scatter_mean_accumulate
	import sma_pkg::*;
#(
	parameter int unsigned VOXELS   = VOXELS_DEF,
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// voxel_index, channel_index, feature_value, voxel_count, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// func
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// entry_value
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// skipped
	output logic [0:0]            m_axis_tuser
);

	localparam int unsigned DEPTH     = VOXELS * CHANNELS;
	localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned DIV_CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	state_t state_q, state_next;

	// unpack the input transfer
	logic [VOXEL_W-1:0] in_voxel;
	logic [CHAN_W-1:0]  in_chan;
	logic [VALUE_W-1:0] in_value;
	logic [COUNT_W-1:0] in_count;
	func_t              in_func;

	assign in_voxel = s_axis_tdata[VOXEL_W-1:0];
	assign in_chan  = s_axis_tdata[VOXEL_W +: CHAN_W];
	assign in_value = s_axis_tdata[VOXEL_W+CHAN_W +: VALUE_W];
	assign in_count = s_axis_tdata[VOXEL_W+CHAN_W+VALUE_W +: COUNT_W];
	assign in_func  = func_t'(s_axis_tuser[0]);

	logic in_xfer;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// entry address and range check, row-major: voxel * CHANNELS + channel
	logic              in_range;
	logic [ADDR_W-1:0] in_addr;

	assign in_range = (32'(in_voxel) < 32'(VOXELS)) && (32'(in_chan) < 32'(CHANNELS));
	assign in_addr  = ADDR_W'(32'(in_voxel) * 32'(CHANNELS) + 32'(in_chan));

	// captured item
	func_t              func_q;
	logic               in_range_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COUNT_W-1:0] count_q;
	logic               neg_q;

	// divider: dvd_q shifts out dividend magnitude and collects the quotient
	logic [VALUE_W-1:0]   dvd_q, dvd_next;
	logic [COUNT_W-1:0]   rem_q, rem_next;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [COUNT_W:0]     div_trial;
	logic                 div_last;

	always_comb begin
		rem_next  = rem_q;
		dvd_next  = dvd_q;
		div_trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			div_trial = {rem_next, dvd_next[VALUE_W-1]};
			if (div_trial >= {1'b0, count_q}) begin
				rem_next = COUNT_W'(div_trial - {1'b0, count_q});
				dvd_next = {dvd_next[VALUE_W-2:0], 1'b1};
			end else begin
				rem_next = div_trial[COUNT_W-1:0];
				dvd_next = {dvd_next[VALUE_W-2:0], 1'b0};
			end
		end
	end

	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_ITERS - 1));

	// table memory, one read or one write a cycle
	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] mem_rdata_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               mem_re, mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;

	// output register
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_skip_q;
	logic               out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	// signed quotient and saturating sum
	logic signed [VALUE_W:0]   quot;
	logic signed [VALUE_W+1:0] sum_wide;
	logic [VALUE_W-1:0]        sum_sat;

	assign quot     = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign sum_wide = $signed({{2{mem_rdata_q[VALUE_W-1]}}, mem_rdata_q})
	                + $signed({quot[VALUE_W], quot});

	always_comb begin
		if (sum_wide[VALUE_W+1:VALUE_W-1] == 3'b000 || sum_wide[VALUE_W+1:VALUE_W-1] == 3'b111) begin
			sum_sat = sum_wide[VALUE_W-1:0];
		end else if (sum_wide[VALUE_W+1]) begin
			sum_sat = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

	// result of the write-back cycle
	logic               wb_do;
	logic [VALUE_W-1:0] wb_value;
	logic               wb_skip;
	logic               wb_write;

	always_comb begin
		wb_value = '0;
		wb_skip  = 1'b0;
		wb_write = 1'b0;
		if (in_range_q) begin
			if (func_q == FUNC_READ) begin
				wb_value = mem_rdata_q;
				wb_write = 1'b1;
			end else if (count_q == '0) begin
				wb_value = mem_rdata_q;
				wb_skip  = 1'b1;
			end else begin
				wb_value = sum_sat;
				wb_write = 1'b1;
			end
		end
	end

	assign wb_do = (state_q == ST_WRITE) && out_free;

	// read clears the entry; an accumulate with nonzero count stores the saturated sum
	always_comb begin
		mem_re    = (state_q == ST_READ) && in_range_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
		end else if (wb_do && wb_write) begin
			mem_we    = 1'b1;
			mem_wdata = (func_q == FUNC_READ) ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[addr_q];
		end
	end

	// sequencer
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_func == FUNC_ACCUMULATE && in_count != '0 && in_range) begin
						state_next = ST_DIV;
					end else begin
						state_next = ST_READ;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (in_xfer) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (wb_do) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and divider datapath, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q     <= in_func;
			in_range_q <= in_range;
			addr_q     <= in_addr;
			count_q    <= in_count;
			neg_q      <= in_value[VALUE_W-1];
			dvd_q      <= in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
			rem_q      <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
		end
		if (wb_do) begin
			out_value_q <= wb_value;
			out_skip_q  <= wb_skip;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = OUT_DATA_W'(out_value_q);
	assign m_axis_tuser[0] = out_skip_q;

	// a transfer always heads for the divider or straight to the table read
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_DIV || state_q == ST_READ))
		else $error("accepted item did not enter divide or read");

	// the table is written only by the clearing sweep or a write-back
	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
		else $error("table written outside sweep or write-back");

	// a skipped flag comes only from an in-range accumulate with zero count
	a_skip_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_do && wb_skip) |-> (func_q == FUNC_ACCUMULATE && count_q == '0 && in_range_q))
		else $error("skip flag without a zero-count accumulate");

	// the divider does not leave before its last iteration
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !div_last) |=> state_q == ST_DIV)
		else $error("divider left early");

endmodule

FILE: sim/scatter_mean_accumulate_tb.sv
`timescale 1ns / 100ps

module scatter_mean_accumulate_tb;
	import sma_pkg::*;

	localparam int unsigned TABLE_DEPTH = VOXELS_DEF * CHANNELS_DEF;
	// no transfer for this long means the block is hung (longer than the reset sweep)
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned ITEMS_PER_PHASE = 450;

	typedef struct {
		func_t              func;
		logic [7:0]         voxel;
		logic [3:0]         chan;
		logic signed [31:0] value;
		logic [15:0]        count;
	} scatter_req_t;

	typedef struct {
		logic signed [31:0] entry;
		logic               skipped;
	} scatter_res_t;

	typedef struct {
		scatter_req_t req;
		bit           typed;
		scatter_res_t result;
	} scatter_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// voxel_index, channel_index, feature_value, voxel_count, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// func
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// entry_value
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// skipped
	logic [0:0]            m_axis_tuser;

	logic signed [31:0] mean_copy [TABLE_DEPTH];
	scatter_res_t       pending_results [$];
	scatter_row_t       directed_rows [$];
	scatter_res_t       oldest_result;
	int unsigned        mismatch_count;
	int unsigned        idle_cycles;
	int unsigned        src_idle_pct;
	int unsigned        sink_stall_pct;

	scatter_mean_accumulate u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mirror of the voxel table: divide, saturating add, or read and clear
	function automatic scatter_res_t predict_scatter_mean(input scatter_req_t req);
		scatter_res_t res;
		int unsigned  addr;
		longint       dividend;
		longint       divisor;
		longint       sum;
		res.entry   = '0;
		res.skipped = 1'b0;
		// index outside the table: no access, all-zero result
		if (req.voxel >= VOXELS_DEF || req.chan >= CHANNELS_DEF)
			return res;
		addr = int'(req.voxel) * CHANNELS_DEF + int'(req.chan);
		if (req.func == FUNC_READ) begin
			res.entry       = mean_copy[addr];
			mean_copy[addr] = '0;
		end else if (req.count == '0) begin
			// zero count leaves the entry alone and flags it
			res.entry   = mean_copy[addr];
			res.skipped = 1'b1;
		end else begin
			dividend = req.value;
			divisor  = req.count;
			// signed division truncates toward zero
			sum = longint'(mean_copy[addr]) + dividend / divisor;
			if (sum > longint'(32'sh7FFF_FFFF))
				sum = longint'(32'sh7FFF_FFFF);
			else if (sum < -longint'(64'h8000_0000))
				sum = -longint'(64'h8000_0000);
			mean_copy[addr] = sum[31:0];
			res.entry       = sum[31:0];
		end
		return res;
	endfunction

	// most traffic lands on four hot entries so sums build up and saturate
	function automatic scatter_req_t random_request();
		scatter_req_t req;
		int unsigned  hot;
		int unsigned  pick;
		req.func = ($urandom_range(0, 99) < 20) ? FUNC_READ : FUNC_ACCUMULATE;
		if ($urandom_range(0, 99) < 60) begin
			hot       = $urandom_range(0, 3);
			req.voxel = 8'(hot * 85);
			req.chan  = 4'(hot * 5);
		end else begin
			req.voxel = 8'($urandom_range(0, 255));
			req.chan  = 4'($urandom_range(0, 15));
		end
		pick = $urandom_range(0, 99);
		if (pick < 5)
			req.value = 32'sh7FFF_FFFF;
		else if (pick < 10)
			req.value = 32'sh8000_0000;
		else if (pick < 13)
			req.value = -32'sd1;
		else
			req.value = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			req.count = '0;
		else if (pick < 50)
			req.count = 16'($urandom_range(1, 4));
		else if (pick < 75)
			req.count = 16'($urandom_range(1, 255));
		else
			req.count = 16'($urandom_range(0, 65535));
		return req;
	endfunction

	task automatic add_row(input func_t func, input logic [7:0] voxel, input logic [3:0] chan,
			input logic [31:0] value, input logic [15:0] count, input bit typed,
			input logic [31:0] entry, input logic skipped);
		scatter_row_t row;
		row.req.func       = func;
		row.req.voxel      = voxel;
		row.req.chan       = chan;
		row.req.value      = value;
		row.req.count      = count;
		row.typed          = typed;
		row.result.entry   = entry;
		row.result.skipped = skipped;
		directed_rows.push_back(row);
	endtask

	// offer one item, hold it until the transfer, then record what must come back
	task automatic send_request(input scatter_req_t req, input bit typed,
			input scatter_res_t typed_res);
		scatter_res_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, req.count, req.value, req.chan, req.voxel};
		s_axis_tuser  <= req.func;
		do
			@(posedge clk);
		while (!s_axis_tready);
		// predictor always runs so the mirrored table stays in step
		predicted = predict_scatter_mean(req);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// receiver side: random back-pressure
	initial m_axis_tready = 1'b0;
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// result checker against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: entry_value %h skipped %b",
					m_axis_tdata[31:0], m_axis_tuser[0]);
				mismatch_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== oldest_result.entry) begin
					$error("entry_value: expected %h, actual %h",
						oldest_result.entry, m_axis_tdata[31:0]);
					mismatch_count++;
				end
				if (m_axis_tuser[0] !== oldest_result.skipped) begin
					$error("skipped: expected %b, actual %b",
						oldest_result.skipped, m_axis_tuser[0]);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		mismatch_count = 0;
		idle_cycles    = 0;
		src_idle_pct   = 28;
		sink_stall_pct = 76;
		foreach (mean_copy[i])
			mean_copy[i] = '0;

		// empty table after reset
		add_row(FUNC_READ, 8'd0, 4'd0, 32'h0, 16'h0, 1, 32'h0000_0000, 1'b0);
		// top corner, maximum value, then saturation at the top
		add_row(FUNC_ACCUMULATE, 8'd255, 4'd15, 32'h7FFF_FFFF, 16'd1, 1, 32'h7FFF_FFFF, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd255, 4'd15, 32'h7FFF_FFFF, 16'd1, 1, 32'h7FFF_FFFF, 1'b0);
		// read returns the entry, a second read sees it cleared
		add_row(FUNC_READ, 8'd255, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'h7FFF_FFFF, 1'b0);
		add_row(FUNC_READ, 8'd255, 4'd15, 32'h0, 16'h0, 1, 32'h0000_0000, 1'b0);
		// minimum value, then saturation at the bottom
		add_row(FUNC_ACCUMULATE, 8'd0, 4'd0, 32'h8000_0000, 16'd1, 1, 32'h8000_0000, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd0, 4'd0, 32'h8000_0000, 16'd1, 1, 32'h8000_0000, 1'b0);
		// zero count: skipped, entry unchanged
		add_row(FUNC_ACCUMULATE, 8'd0, 4'd0, 32'h1234_5678, 16'd0, 1, 32'h8000_0000, 1'b1);
		// read ignores the count
		add_row(FUNC_READ, 8'd0, 4'd0, 32'h0, 16'hFFFF, 1, 32'h8000_0000, 1'b0);
		// negative quotient truncates toward zero
		add_row(FUNC_ACCUMULATE, 8'd1, 4'd2, 32'hFFFF_FFF9, 16'd2, 1, 32'hFFFF_FFFD, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd1, 4'd2, 32'h0000_0007, 16'd2, 0, '0, 1'b0);
		// largest divisor with extreme values, then a small divisor, a read and a zero count
		add_row(FUNC_ACCUMULATE, 8'd3, 4'd4, 32'h7FFF_FFFF, 16'hFFFF, 0, '0, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd3, 4'd4, 32'h8000_0000, 16'hFFFF, 0, '0, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd3, 4'd4, 32'hFFFF_FFFF, 16'd3, 0, '0, 1'b0);
		add_row(FUNC_READ, 8'd3, 4'd4, 32'h0, 16'h0, 0, '0, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd128, 4'd8, 32'h0001_2345, 16'd0, 1, 32'h0000_0000, 1'b1);
		// alternating bit patterns on every field
		add_row(FUNC_ACCUMULATE, 8'd85, 4'd10, 32'h5555_5555, 16'h5555, 0, '0, 1'b0);
		add_row(FUNC_ACCUMULATE, 8'd170, 4'd5, 32'hAAAA_AAAA, 16'hAAAA, 0, '0, 1'b0);
		add_row(FUNC_READ, 8'd85, 4'd10, 32'hAAAA_AAAA, 16'hAAAA, 0, '0, 1'b0);
		add_row(FUNC_READ, 8'd170, 4'd5, 32'h5555_5555, 16'h5555, 0, '0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed,
				directed_rows[i].result);

		// three idling phases: slow receiver, slow sender, full speed
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct   = (phase == 0) ? 28 : (phase == 1) ? 76 : 0;
			sink_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 28 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(random_request(), 0, '{entry: '0, skipped: 1'b0});
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// let any stray result surface
		repeat (24) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
